@@ design/cfgchk_pkg.sv @@
// Shared constants, types and helper functions for the settings record checker.
package cfgchk_pkg;

  localparam int RECORD_BYTES = 32;
  localparam int POS_W        = $clog2(RECORD_BYTES);
  localparam int QUEUE_DEPTH  = 2;

  // Byte offsets of the record sections.
  localparam int POS_VERSION  = 4;
  localparam int POS_ID       = 8;
  localparam int POS_WIDTH    = 12;
  localparam int POS_HEIGHT   = 16;
  localparam int POS_GAIN     = 20;
  localparam int POS_MODE     = 22;
  localparam int POS_PAD      = 24;
  localparam int HASHED_BYTES = 28;

  localparam logic [31:0] HASH_BASIS     = 32'd2166136261;
  localparam logic [7:0]  FORMAT_VERSION = 8'd1;
  localparam logic [31:0] WIDTH_MIN      = 32'd160;
  localparam logic [31:0] WIDTH_MAX      = 32'd8192;
  localparam logic [31:0] HEIGHT_MIN     = 32'd120;
  localparam logic [31:0] HEIGHT_MAX     = 32'd8192;
  localparam logic [15:0] GAIN_MAX       = 16'd256;
  localparam logic [15:0] MODE_MAX       = 16'd1;

  typedef enum logic [3:0] {
    KIND_MAGIC,
    KIND_VERSION,
    KIND_ID,
    KIND_WIDTH,
    KIND_HEIGHT,
    KIND_GAIN,
    KIND_MODE,
    KIND_PAD,
    KIND_SUM
  } kind_t;

  // One classified byte, front to back.
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       hashed;
    logic       hdr_bad;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h42;  // B
      2'd1:    b = 8'h53;  // S
      2'd2:    b = 8'h43;  // C
      default: b = 8'h46;  // F
    endcase
    return b;
  endfunction

  // FNV-1a step; prime 0x01000193 as shifts: bits 0,1,4,7,8,24.
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

endpackage

@@ design/cfgchk_intf.sv @@
// Channel interfaces: record byte stream in, decoded record result out.
interface byte_stream_if;
  import cfgchk_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface record_result_if;
  import cfgchk_pkg::*;
  logic        valid;
  logic        ready;
  logic        record_ok;
  logic [31:0] game_id;
  logic [31:0] window_width;
  logic [31:0] window_height;
  logic [15:0] gain_q8;
  logic        fullscreen;

  modport source(output valid, output record_ok, output game_id, output window_width,
                 output window_height, output gain_q8, output fullscreen, input ready);
  modport sink(input valid, input record_ok, input game_id, input window_width,
               input window_height, input gain_q8, input fullscreen, output ready);
endinterface

@@ design/cfgchk_front.sv @@
// Front end: takes record bytes, tracks position and classifies each byte.
module cfgchk_front (
  input  logic                clk,
  input  logic                rst_n,
  byte_stream_if.sink         in_chan,
  input  cfgchk_pkg::q_status_t q_status,
  output logic                push,
  output cfgchk_pkg::cmd_t    push_cmd
);
  import cfgchk_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;

  assign in_chan.ready = !q_status.full;
  assign push          = in_chan.valid && !q_status.full;

  // Wraps naturally at the record length.
  assign pos_nxt = push ? pos_r + 1'b1 : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    push_cmd.data    = in_chan.data_byte;
    push_cmd.hashed  = pos_r < POS_W'(HASHED_BYTES);
    push_cmd.last    = pos_r == POS_W'(RECORD_BYTES - 1);
    push_cmd.hdr_bad = 1'b0;
    if (pos_r < POS_W'(POS_VERSION)) begin
      push_cmd.kind    = KIND_MAGIC;
      push_cmd.hdr_bad = in_chan.data_byte != magic_byte(pos_r[1:0]);
    end else if (pos_r < POS_W'(POS_ID)) begin
      push_cmd.kind    = KIND_VERSION;
      push_cmd.hdr_bad = in_chan.data_byte !=
                         ((pos_r == POS_W'(POS_VERSION)) ? FORMAT_VERSION : 8'd0);
    end else if (pos_r < POS_W'(POS_WIDTH)) begin
      push_cmd.kind = KIND_ID;
    end else if (pos_r < POS_W'(POS_HEIGHT)) begin
      push_cmd.kind = KIND_WIDTH;
    end else if (pos_r < POS_W'(POS_GAIN)) begin
      push_cmd.kind = KIND_HEIGHT;
    end else if (pos_r < POS_W'(POS_MODE)) begin
      push_cmd.kind = KIND_GAIN;
    end else if (pos_r < POS_W'(POS_PAD)) begin
      push_cmd.kind = KIND_MODE;
    end else if (pos_r < POS_W'(HASHED_BYTES)) begin
      push_cmd.kind = KIND_PAD;
    end else begin
      push_cmd.kind = KIND_SUM;
    end
  end

endmodule

@@ design/cfgchk_fifo.sv @@
// Short queue of classified bytes between front and back.
module cfgchk_fifo #(
  parameter int DEPTH = cfgchk_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cfgchk_pkg::cmd_t      push_cmd,
  input  logic                  pop,
  output cfgchk_pkg::cmd_t      head,
  output cfgchk_pkg::q_status_t status
);
  import cfgchk_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head         = slots_r[rd_ptr_r];
  assign status.full  = count_r == CNT_W'(DEPTH);
  assign status.empty = count_r == '0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ design/cfgchk_back.sv @@
// Back end: hash, field collection, final checks and the result register.
module cfgchk_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfgchk_pkg::cmd_t      head,
  input  cfgchk_pkg::q_status_t q_status,
  output logic                  pop,
  record_result_if.source       out_chan
);
  import cfgchk_pkg::*;

  logic [31:0] hash_r, hash_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [15:0] gain_r, gain_nxt;
  logic [15:0] mode_r, mode_nxt;
  logic [31:0] sum_r, sum_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r;
  logic [31:0] out_id_r;
  logic [31:0] out_width_r;
  logic [31:0] out_height_r;
  logic [15:0] out_gain_r;
  logic        out_full_r;

  logic        load;
  logic        rec_ok;

  // A last byte waits until the result register is free or being drained.
  assign pop  = !q_status.empty && (!head.last || !out_valid_r || out_chan.ready);
  assign load = pop && head.last;

  always_comb begin
    hash_nxt     = hash_r;
    hdr_good_nxt = hdr_good_r;
    id_nxt       = id_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    gain_nxt     = gain_r;
    mode_nxt     = mode_r;
    sum_nxt      = sum_r;
    if (pop) begin
      if (head.hashed) begin
        hash_nxt = fnv_step(hash_r, head.data);
      end
      hdr_good_nxt = hdr_good_r && !head.hdr_bad;
      unique case (head.kind)
        KIND_ID:     id_nxt     = {head.data, id_r[31:8]};
        KIND_WIDTH:  width_nxt  = {head.data, width_r[31:8]};
        KIND_HEIGHT: height_nxt = {head.data, height_r[31:8]};
        KIND_GAIN:   gain_nxt   = {head.data, gain_r[15:8]};
        KIND_MODE:   mode_nxt   = {head.data, mode_r[15:8]};
        KIND_SUM:    sum_nxt    = {head.data, sum_r[31:8]};
        default:     ;
      endcase
    end
  end

  assign rec_ok = hdr_good_nxt && (sum_nxt == hash_nxt) && (mode_nxt <= MODE_MAX) &&
                  (width_nxt >= WIDTH_MIN) && (width_nxt <= WIDTH_MAX) &&
                  (height_nxt >= HEIGHT_MIN) && (height_nxt <= HEIGHT_MAX) &&
                  (gain_nxt <= GAIN_MAX);

  assign out_valid_nxt = load || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n || load) begin
      hash_r     <= HASH_BASIS;
      hdr_good_r <= 1'b1;
      id_r       <= '0;
      width_r    <= '0;
      height_r   <= '0;
      gain_r     <= '0;
      mode_r     <= '0;
      sum_r      <= '0;
    end else begin
      hash_r     <= hash_nxt;
      hdr_good_r <= hdr_good_nxt;
      id_r       <= id_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      gain_r     <= gain_nxt;
      mode_r     <= mode_nxt;
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ok_r     <= rec_ok;
      out_id_r     <= id_nxt;
      out_width_r  <= width_nxt;
      out_height_r <= height_nxt;
      out_gain_r   <= gain_nxt;
      out_full_r   <= mode_nxt != '0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.record_ok     = out_ok_r;
  assign out_chan.game_id       = out_id_r;
  assign out_chan.window_width  = out_width_r;
  assign out_chan.window_height = out_height_r;
  assign out_chan.gain_q8       = out_gain_r;
  assign out_chan.fullscreen    = out_full_r;

endmodule

@@ design/config_record_checker.sv @@
// Top level of the settings record checker.
// Accepts a 32-byte settings record one byte per transaction, byte 0 first,
// and after byte 31 delivers one result transaction with the decoded game id,
// window size, Q8 gain, fullscreen flag and record_ok. record_ok is set only
// when the magic reads BSCF, the version word is 1, the FNV-1a 32 hash of
// bytes 0..27 equals the little-endian word in bytes 28..31, the fullscreen
// halfword is 0 or 1, width is 160..8192, height is 120..8192 and gain is at
// most 256. Fields of a rejected record are still reported. There is no
// framing: the byte counter simply wraps after byte 31, so the stream must
// start aligned to a record. Throughput is one byte per clock while the queue
// has room; the hash update is a single shift-add step per byte in the back
// end. A last byte is written into the queue, and its pop loads the result
// register that drives the result valid. The front end (byte counter and
// classifier) and back end (hash, field capture, checks, result register) are
// split by a QUEUE_DEPTH-entry queue, so input keeps flowing while a result
// waits; input stalls only once the queue fills behind a last byte whose
// previous result has not been taken.
module config_record_checker #(
  parameter int QUEUE_DEPTH = cfgchk_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  byte_stream_if.sink     in_chan,
  record_result_if.source out_chan
);
  import cfgchk_pkg::*;

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;
  q_status_t q_status;

  // Position tracking and byte classification.
  cfgchk_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decoupling queue.
  cfgchk_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Hashing, field capture and result.
  cfgchk_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // Queue can never report full and empty together.
  a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  // Back end only drains a queue that holds something.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // A new result appears only after the last byte of a record was consumed.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(pop && head.last))
    else $error("result without a completed record");

  // Input is never refused while the queue has room.
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    !q_status.full |-> in_chan.ready)
    else $error("input stalled with queue space free");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the settings record checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cfgchk_pkg::*;

  localparam logic [31:0] FNV_PRIME      = 32'd16777619;
  // Bytes 0..7 of a good record, little-endian: "BSCF" then version word 1.
  localparam logic [31:0] MAGIC_LE       = 32'h4643_5342;
  localparam logic [63:0] HEADER_LE      = {32'h0000_0001, MAGIC_LE};
  localparam int          RANDOM_BYTES   = 1700;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          TAIL_CYCLES    = 40;
  localparam int          FROM_MODEL     = -1;

  // One decoded record as the result channel carries it.
  typedef struct packed {
    logic        record_ok;
    logic [31:0] game_id;
    logic [31:0] window_width;
    logic [31:0] window_height;
    logic [15:0] gain_q8;
    logic        fullscreen;
  } decoded_rec_t;

  // Parse state of the checker, mirrored byte for byte.
  typedef struct packed {
    logic [4:0]  pos;
    logic [31:0] hash;
    logic        hdr_ok;
    logic [31:0] id;
    logic [31:0] wd;
    logic [31:0] ht;
    logic [15:0] gain;
    logic [15:0] mode;
    logic [31:0] sum;
  } scan_state_t;

  // Field-level description of one record to send.
  typedef struct packed {
    logic [31:0] magic;
    logic [31:0] version;
    logic [31:0] game_id;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] gain;
    logic [15:0] mode;
    logic [31:0] pad;
    logic [31:0] sum_flip;   // xor mask on the correct checksum
    logic        typed;      // expectation written out in the table
    logic        typed_ok;
  } record_row_t;

  logic clk = 1'b0;
  logic rst_n;

  byte_stream_if   in_chan();
  record_result_if out_chan();

  config_record_checker dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  scan_state_t  scan;
  decoded_rec_t expected_records[$];
  record_row_t  dir_rows[$];
  int           fail_count  = 0;
  int           bytes_sent  = 0;
  int           stall_cycles = 0;
  bit           calm        = 1'b0;   // both sides run without idling while set

  function automatic logic [31:0] fnv1a(input logic [31:0] h, input logic [7:0] b);
    return (h ^ {24'd0, b}) * FNV_PRIME;
  endfunction

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic reset_scan();
    scan        = '0;
    scan.hash   = HASH_BASIS;
    scan.hdr_ok = 1'b1;
  endtask

  // Advance the mirrored parse state by one byte; done marks byte 31.
  task automatic decode_record_byte(input logic [7:0] b, output bit done,
                                    output decoded_rec_t rec);
    int p;
    p    = scan.pos;
    done = 1'b0;
    rec  = '0;
    if (p < HASHED_BYTES) scan.hash = fnv1a(scan.hash, b);
    if (p < POS_ID) begin
      if (b != HEADER_LE[p*8 +: 8]) scan.hdr_ok = 1'b0;
    end else if (p < POS_WIDTH) begin
      scan.id = {b, scan.id[31:8]};
    end else if (p < POS_HEIGHT) begin
      scan.wd = {b, scan.wd[31:8]};
    end else if (p < POS_GAIN) begin
      scan.ht = {b, scan.ht[31:8]};
    end else if (p < POS_MODE) begin
      scan.gain = {b, scan.gain[15:8]};
    end else if (p < POS_PAD) begin
      scan.mode = {b, scan.mode[15:8]};
    end else if (p >= HASHED_BYTES) begin
      scan.sum = {b, scan.sum[31:8]};
    end
    if (p == RECORD_BYTES - 1) begin
      done              = 1'b1;
      rec.record_ok     = scan.hdr_ok && (scan.sum == scan.hash) && (scan.mode <= MODE_MAX) &&
                          (scan.wd >= WIDTH_MIN) && (scan.wd <= WIDTH_MAX) &&
                          (scan.ht >= HEIGHT_MIN) && (scan.ht <= HEIGHT_MAX) &&
                          (scan.gain <= GAIN_MAX);
      rec.game_id       = scan.id;
      rec.window_width  = scan.wd;
      rec.window_height = scan.ht;
      rec.gain_q8       = scan.gain;
      rec.fullscreen    = (scan.mode != 16'd0);
      reset_scan();
    end else begin
      scan.pos = 5'(p + 1);
    end
  endtask

  // Lay the fields out little-endian and append the checksum of bytes 0..27.
  function automatic logic [255:0] pack_record(input record_row_t row);
    logic [255:0] rb;
    logic [31:0]  h;
    rb          = '0;
    rb[31:0]    = row.magic;
    rb[63:32]   = row.version;
    rb[95:64]   = row.game_id;
    rb[127:96]  = row.width;
    rb[159:128] = row.height;
    rb[175:160] = row.gain;
    rb[191:176] = row.mode;
    rb[223:192] = row.pad;
    h = HASH_BASIS;
    for (int i = 0; i < HASHED_BYTES; i++) h = fnv1a(h, rb[i*8 +: 8]);
    rb[255:224] = h ^ row.sum_flip;
    return rb;
  endfunction

  // Table row; ok = FROM_MODEL leaves the expectation to the predictor.
  function automatic record_row_t mk_row(input logic [31:0] magic, input logic [31:0] version,
                                         input logic [31:0] id, input logic [31:0] w,
                                         input logic [31:0] h, input logic [15:0] gain,
                                         input logic [15:0] mode, input logic [31:0] flip,
                                         input int ok);
    record_row_t r;
    r.magic    = magic;
    r.version  = version;
    r.game_id  = id;
    r.width    = w;
    r.height   = h;
    r.gain     = gain;
    r.mode     = mode;
    r.pad      = 32'd0;
    r.sum_flip = flip;
    r.typed    = (ok != FROM_MODEL);
    r.typed_ok = (ok == 1);
    return r;
  endfunction

  // Window dimension biased toward the range edges.
  function automatic logic [31:0] pick_dim(input logic [31:0] lo);
    case ($urandom_range(0, 7))
      0:       return lo - 1;
      1:       return lo;
      2:       return WIDTH_MAX;
      3:       return WIDTH_MAX + 1;
      default: return $urandom_range(lo, WIDTH_MAX);
    endcase
  endfunction

  // Mostly well-formed record with random content, sometimes one field broken.
  task automatic make_random_row(output record_row_t row);
    row = mk_row(MAGIC_LE, 32'd1, $urandom, pick_dim(WIDTH_MIN), pick_dim(HEIGHT_MIN),
                 16'd0, 16'($urandom_range(0, 1)), 32'd0, FROM_MODEL);
    row.pad = $urandom;
    case ($urandom_range(0, 3))
      0:       row.gain = GAIN_MAX;
      1:       row.gain = GAIN_MAX + 16'd1;
      default: row.gain = 16'($urandom_range(0, GAIN_MAX));
    endcase
    case ($urandom_range(0, 11))
      0: row.magic    = row.magic ^ (32'd1 << $urandom_range(0, 31));
      1: row.version  = row.version ^ (32'd1 << $urandom_range(0, 31));
      2: row.sum_flip = 32'd1 << $urandom_range(0, 31);
      3: row.mode     = 16'($urandom);
      4: row.gain     = 16'($urandom);
      5: row.width    = $urandom;
      6: row.height   = $urandom;
      default: ;
    endcase
  endtask

  // Offer one byte, hold it until taken, then update the prediction.
  task automatic push_byte(input logic [7:0] b, input bit use_typed,
                           input decoded_rec_t typed_rec);
    int           gap;
    bit           done;
    decoded_rec_t rec;
    gap = idle_draw();
    repeat (gap) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
    decode_record_byte(b, done, rec);
    if (done) expected_records.push_back(use_typed ? typed_rec : rec);
  endtask

  task automatic send_record(input record_row_t row);
    logic [255:0] rb;
    decoded_rec_t typed_rec;
    rb                      = pack_record(row);
    typed_rec.record_ok     = row.typed_ok;
    typed_rec.game_id       = row.game_id;
    typed_rec.window_width  = row.width;
    typed_rec.window_height = row.height;
    typed_rec.gain_q8       = row.gain;
    typed_rec.fullscreen    = (row.mode != 16'd0);
    for (int i = 0; i < RECORD_BYTES; i++)
      push_byte(rb[i*8 +: 8], row.typed && (i == RECORD_BYTES - 1), typed_rec);
  endtask

  task automatic send_noise(input int n);
    repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // Drop valid and hold off until every predicted result is back.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Directed table: range edges, each header/checksum failure, odd fullscreen words.
  initial begin
    record_row_t r;
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'h0, 160, 120, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'hFFFF_FFFF, 8192, 8192, 256, 1, 0, 1));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'h1234_5678, 159, 600, 128, 0, 0, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'h1234_5678, 8193, 600, 128, 0, 0, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'h1234_5678, 800, 119, 128, 0, 0, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'h1234_5678, 800, 8193, 128, 1, 0, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'h8765_4321, 800, 600, 257, 0, 0, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'h8765_4321, 800, 600, 16'hFFFF, 1, 0, 0));
    // fullscreen word above one: rejected, but the flag still reads 1
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'h0000_00A5, 800, 600, 256, 2, 0, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'h0000_00A5, 800, 600, 0, 16'h0100, 0, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'h0000_00A5, 800, 600, 0, 16'hFFFF, 0, 0));
    dir_rows.push_back(mk_row(32'h4643_5343, 1, 32'h5A5A_5A5A, 640, 480, 64, 0, 0, 0));
    dir_rows.push_back(mk_row(32'h4743_5342, 1, 32'h5A5A_5A5A, 640, 480, 64, 0, 0, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 0, 32'h5A5A_5A5A, 640, 480, 64, 1, 0, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 2, 32'h5A5A_5A5A, 640, 480, 64, 1, 0, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 32'h8000_0001, 32'h5A5A_5A5A, 640, 480, 64, 0, 0, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'hC0DE_0001, 1024, 768, 200, 0, 32'h1, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'hC0DE_0002, 1024, 768, 200, 1, 32'h8000_0000, 0));
    dir_rows.push_back(mk_row(MAGIC_LE, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row('1, '1, '1, '1, '1, '1, '1, '1, 0));
    // padding bytes are hashed but never checked on their own
    r = mk_row(MAGIC_LE, 1, 32'h0BAD_F00D, 1920, 1080, 256, 1, 0, FROM_MODEL);
    r.pad = 32'hFFFF_FFFF;
    dir_rows.push_back(r);
    r = mk_row(MAGIC_LE, 1, 32'h7F7F_7F7F, 160, 8192, 1, 0, 0, FROM_MODEL);
    r.pad = 32'h8001_7FFE;
    dir_rows.push_back(r);
  end

  // Sender: reset, directed table, then random traffic.
  initial begin
    record_row_t r;
    int          k;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.data_byte = 8'd0;
    reset_scan();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      calm = (i % 5 == 4);
      send_record(dir_rows[i]);
    end
    // hold off until the directed results are all back
    wait_drained();

    while (bytes_sent < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0, 1: send_noise(RECORD_BYTES);
        2: begin
          // record slipped by k bytes, then realigned with filler
          k = $urandom_range(1, RECORD_BYTES - 1);
          make_random_row(r);
          send_noise(k);
          send_record(r);
          send_noise(RECORD_BYTES - k);
        end
        default: begin
          make_random_row(r);
          send_record(r);
        end
      endcase
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    in_chan.valid <= 1'b0;

    while (expected_records.size() != 0) @(posedge clk);
    // catch any stray late result
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Receiver: random back-pressure, each result checked against the oldest prediction.
  initial begin
    decoded_rec_t got;
    decoded_rec_t want;
    int           gap;
    out_chan.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_draw();
      repeat (gap) begin
        out_chan.ready <= 1'b0;
        @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      got.record_ok     = out_chan.record_ok;
      got.game_id       = out_chan.game_id;
      got.window_width  = out_chan.window_width;
      got.window_height = out_chan.window_height;
      got.gain_q8       = out_chan.gain_q8;
      got.fullscreen    = out_chan.fullscreen;
      if (expected_records.size() == 0) begin
        $error("result transaction with no record pending: id 0x%0h", got.game_id);
        fail_count++;
      end else begin
        want = expected_records.pop_front();
        check_field("record_ok", want.record_ok, got.record_ok);
        check_field("game_id", want.game_id, got.game_id);
        check_field("window_width", want.window_width, got.window_width);
        check_field("window_height", want.window_height, got.window_height);
        check_field("gain_q8", want.gain_q8, got.gain_q8);
        check_field("fullscreen", want.fullscreen, got.fullscreen);
      end
    end
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
